// ===== rtl/gdjs_pkg.sv =====
// ----------------------------------------------------------------------------
// Greedy deadline job scheduler package
// Field widths, result kinds, cell commands and the job record that moves
// along the cell chain.
// ----------------------------------------------------------------------------
package gdjs_pkg;

   localparam int TAG_W    = 8;
   localparam int DL_W     = 6;
   localparam int PROFIT_W = 16;
   localparam int SLOT_W   = 6;
   localparam int AMOUNT_W = 22;
   localparam int KIND_W   = 2;

   localparam logic [KIND_W-1:0] KIND_SCHEDULED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TOTAL     = 2'd2;

   // Operations that the controller broadcasts to every cell.
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_SHIFT  = 2'd2;

   typedef struct packed {
      logic                valid;
      logic                sched;
      logic [TAG_W-1:0]    tag;
      logic [DL_W-1:0]     deadline;
      logic [PROFIT_W-1:0] profit;
   } job_type;

   typedef struct packed {
      logic [1:0] op;
      job_type    new_job;
   } cell_cmd_type;

endpackage

// ===== rtl/gdjs_req_if.sv =====
// ----------------------------------------------------------------------------
// Job request channel
// Valid/ready channel that carries one job per transaction.
// ----------------------------------------------------------------------------
interface gdjs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] job_tag;
   logic [7:0] deadline;
   logic [15:0] profit;
   logic       last_job;

   modport source (output valid, output job_tag, output deadline, output profit,
                   output last_job, input ready);
   modport sink   (input valid, input job_tag, input deadline, input profit,
                   input last_job, output ready);
endinterface

// ===== rtl/gdjs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one scheduling result per transaction.
// ----------------------------------------------------------------------------
interface gdjs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  out_tag;
   logic [5:0]  slot;
   logic [21:0] amount;
   logic        last_result;

   modport source (output valid, output kind, output out_tag, output slot,
                   output amount, output last_result, input ready);
   modport sink   (input valid, input kind, input out_tag, input slot,
                   input amount, input last_result, output ready);
endinterface

// ===== rtl/gdjs_cell.sv =====
// ----------------------------------------------------------------------------
// Scheduler chain cell
// Holds one job of the profit-ordered list; inserts, keeps or shifts.
// ----------------------------------------------------------------------------
module gdjs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  gdjs_pkg::cell_cmd_type cmd,
   input  logic                  left_keep,
   input  gdjs_pkg::job_type     left_job,
   input  gdjs_pkg::job_type     right_job,
   output logic                  keep,
   output gdjs_pkg::job_type     job
);

   logic              valid_ff;
   logic              valid_in;
   gdjs_pkg::job_type data_ff;
   gdjs_pkg::job_type data_in;

   // A cell keeps its job only when it is strictly more profitable, so a new
   // job lands ahead of earlier jobs with the same profit.
   assign keep = valid_ff && (data_ff.profit > cmd.new_job.profit);

   always_comb begin
      job       = data_ff;
      job.valid = valid_ff;
   end

   always_comb begin
      case (cmd.op)
         gdjs_pkg::CELL_INSERT: begin
            if (keep) begin
               data_in = job;
            end else if (left_keep) begin
               data_in = cmd.new_job;
            end else begin
               data_in = left_job;
            end
         end
         gdjs_pkg::CELL_SHIFT: begin
            data_in = right_job;
         end
         default: begin
            data_in = job;
         end
      endcase
      valid_in = data_in.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== rtl/greedy_deadline_job_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Greedy deadline job scheduler core
// Sorts jobs by profit in a chain of cells, assigns each the latest free slot
// at or below its deadline, and reports scheduled jobs, rejects and total.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Contents per transaction
//   req       in          job_tag, deadline, profit, last_job
//   rsp       out         kind, out_tag, slot, amount, last_result
//
// Jobs are taken one per cycle while the block is loading; each one enters
// the sorted cell chain in the same cycle unless the chain is full. The job
// marked last_job starts slot assignment, then the slot sweep (the slot
// table read is registered), the reject sweep and the total; the sweeps
// and the total are held while the result side stalls.
// Reset is synchronous and empties the chain, the slot map and the total.
// New jobs are accepted again as soon as the total transaction is loaded into
// the output register, even while it still waits to be taken.
// ----------------------------------------------------------------------------
module greedy_deadline_job_scheduler_core #(
   parameter int MAX_JOBS = 32
) (
   input  logic    clock,
   input  logic    reset,
   gdjs_req_if.sink   req,
   gdjs_rsp_if.source rsp
);

   localparam int IDX_W = $clog2(MAX_JOBS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_JOBS - 1);
   localparam int MEM_W = gdjs_pkg::TAG_W + gdjs_pkg::PROFIT_W;

   // Controller states.
   localparam logic [2:0] ST_LOAD     = 3'd0;
   localparam logic [2:0] ST_SCHED    = 3'd1;
   localparam logic [2:0] ST_SLOT_RD  = 3'd2;
   localparam logic [2:0] ST_SLOT_OUT = 3'd3;
   localparam logic [2:0] ST_REJ      = 3'd4;
   localparam logic [2:0] ST_TOTAL    = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              step_ff, step_in;
   logic [MAX_JOBS-1:0]           used_ff, used_in;
   logic [gdjs_pkg::AMOUNT_W-1:0] total_ff, total_in;
   logic [MEM_W-1:0]              rd_ff;

   // Slot table: tag and profit of the job placed in each slot.
   logic [MEM_W-1:0] slot_mem [MAX_JOBS];

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gdjs_pkg::KIND_W-1:0]   rsp_kind_ff;
   logic [gdjs_pkg::TAG_W-1:0]    rsp_tag_ff;
   logic [gdjs_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic [gdjs_pkg::AMOUNT_W-1:0] rsp_amount_ff;
   logic                          rsp_last_ff;

   logic                          load_out;
   logic [gdjs_pkg::KIND_W-1:0]   out_kind;
   logic [gdjs_pkg::TAG_W-1:0]    out_tag;
   logic [gdjs_pkg::SLOT_W-1:0]   out_slot;
   logic [gdjs_pkg::AMOUNT_W-1:0] out_amount;
   logic                          out_last;
   logic                          out_free;

   gdjs_pkg::cell_cmd_type cell_cmd;
   gdjs_pkg::job_type      cell_job [MAX_JOBS];
   logic [MAX_JOBS-1:0]    cell_keep;
   gdjs_pkg::job_type      head_job;
   gdjs_pkg::job_type      tail_job;
   gdjs_pkg::job_type      new_job;

   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   logic             place_job;

   // ------------------------------------------------------------------------
   // Cell chain. Cell 0 is the head of the list (highest profit). An insert
   // pushes the jobs of no greater profit one cell to the right; a
   // shift moves every job one cell toward the head and feeds the tail.
   // ------------------------------------------------------------------------
   for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
      logic              left_keep;
      gdjs_pkg::job_type left_job;
      gdjs_pkg::job_type right_job;

      if (i == 0) begin : g_head
         assign left_keep = 1'b1;
         assign left_job  = new_job;
      end else begin : g_body
         assign left_keep = cell_keep[i-1];
         assign left_job  = cell_job[i-1];
      end

      if (i == MAX_JOBS - 1) begin : g_tail
         assign right_job = tail_job;
      end else begin : g_inner
         assign right_job = cell_job[i+1];
      end

      gdjs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cell_cmd),
         .left_keep (left_keep),
         .left_job  (left_job),
         .right_job (right_job),
         .keep      (cell_keep[i]),
         .job       (cell_job[i])
      );
   end

   assign head_job = cell_job[0];

   // Incoming job with its deadline saturated to the number of slots.
   always_comb begin
      new_job.valid  = 1'b1;
      new_job.sched  = 1'b0;
      new_job.tag    = req.job_tag;
      new_job.profit = req.profit;
      if (req.deadline > 8'(MAX_JOBS)) begin
         new_job.deadline = gdjs_pkg::DL_W'(MAX_JOBS);
      end else begin
         new_job.deadline = req.deadline[gdjs_pkg::DL_W-1:0];
      end
   end

   // Latest free slot at or below the head job's deadline. Bit k of the slot
   // map stands for slot k+1, so slot k+1 qualifies when k < deadline. A
   // deadline of zero never finds a slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int k = 0; k < MAX_JOBS; k++) begin
         if (!used_ff[k] && (gdjs_pkg::DL_W'(k) < head_job.deadline)) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(k);
         end
      end
   end

   assign place_job = (state_ff == ST_SCHED) && head_job.valid && free_found;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_LOAD);

   // ------------------------------------------------------------------------
   // Controller.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      step_in           = step_ff;
      used_in           = used_ff;
      total_in          = total_ff;
      cell_cmd.op       = gdjs_pkg::CELL_HOLD;
      cell_cmd.new_job  = new_job;
      tail_job          = '0;
      load_out          = 1'b0;
      out_kind          = gdjs_pkg::KIND_TOTAL;
      out_tag           = '0;
      out_slot          = '0;
      out_amount        = total_ff;
      out_last          = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            if (req.valid) begin
               // A full chain drops the job but still honors its last mark.
               if (count_ff < CNT_W'(MAX_JOBS)) begin
                  cell_cmd.op = gdjs_pkg::CELL_INSERT;
                  count_in    = count_ff + 1'b1;
               end
               if (req.last_job) begin
                  state_in = ST_SCHED;
                  step_in  = '0;
               end
            end
         end

         ST_SCHED: begin
            // The whole chain rotates once, so the list order is restored
            // when the pass ends; each valid head job that finds a free slot is placed and marked.
            cell_cmd.op    = gdjs_pkg::CELL_SHIFT;
            tail_job       = head_job;
            tail_job.sched = place_job;
            if (place_job) begin
               used_in[free_idx] = 1'b1;
               total_in = total_ff + gdjs_pkg::AMOUNT_W'(head_job.profit);
            end
            if (step_ff == LAST_IDX) begin
               state_in = ST_SLOT_RD;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         ST_SLOT_RD: begin
            state_in = ST_SLOT_OUT;
         end

         ST_SLOT_OUT: begin
            if (!used_ff[step_ff] || out_free) begin
               if (used_ff[step_ff]) begin
                  load_out   = 1'b1;
                  out_kind   = gdjs_pkg::KIND_SCHEDULED;
                  out_tag    = rd_ff[MEM_W-1:gdjs_pkg::PROFIT_W];
                  out_slot   = gdjs_pkg::SLOT_W'(step_ff) + 1'b1;
                  out_amount = gdjs_pkg::AMOUNT_W'(rd_ff[gdjs_pkg::PROFIT_W-1:0]);
               end
               if (step_ff == LAST_IDX) begin
                  state_in = ST_REJ;
                  step_in  = '0;
               end else begin
                  state_in = ST_SLOT_RD;
                  step_in  = step_ff + 1'b1;
               end
            end
         end

         ST_REJ: begin
            // Drain the chain in list order; unplaced jobs are reported.
            if (!(head_job.valid && !head_job.sched) || out_free) begin
               if (head_job.valid && !head_job.sched) begin
                  load_out   = 1'b1;
                  out_kind   = gdjs_pkg::KIND_REJECTED;
                  out_tag    = head_job.tag;
                  out_amount = gdjs_pkg::AMOUNT_W'(head_job.profit);
               end
               cell_cmd.op = gdjs_pkg::CELL_SHIFT;
               if (step_ff == LAST_IDX) begin
                  state_in = ST_TOTAL;
                  step_in  = '0;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end

         ST_TOTAL: begin
            if (out_free) begin
               load_out = 1'b1;
               out_last = 1'b1;
               used_in  = '0;
               total_in = '0;
               count_in = '0;
               state_in = ST_LOAD;
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         step_ff      <= '0;
         used_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_kind_ff   <= out_kind;
         rsp_tag_ff    <= out_tag;
         rsp_slot_ff   <= out_slot;
         rsp_amount_ff <= out_amount;
         rsp_last_ff   <= out_last;
      end
   end

   // Slot table: written during assignment, read during the slot sweep.
   always_ff @(posedge clock) begin
      if (place_job) begin
         slot_mem[free_idx] <= {head_job.tag, head_job.profit};
      end
      rd_ff <= slot_mem[step_ff];
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = rsp_kind_ff;
   assign rsp.out_tag     = rsp_tag_ff;
   assign rsp.slot        = rsp_slot_ff;
   assign rsp.amount      = rsp_amount_ff;
   assign rsp.last_result = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_JOBS))
      else $error("job count exceeds the chain length");

   a_one_slot_per_job: assert property (@(posedge clock) disable iff (reset)
      place_job |=> ($countones(used_ff) == $countones($past(used_ff)) + 1))
      else $error("placing a job did not claim exactly one new slot");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TOTAL && out_free) |=>
      (used_ff == '0 && total_ff == '0 && count_ff == '0 && state_ff == ST_LOAD))
      else $error("run state not cleared after the total transaction");

   a_empty_chain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && count_ff == '0) |-> !head_job.valid)
      else $error("cell chain not empty at the start of a set");

   a_total_marks_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ((rsp.kind == gdjs_pkg::KIND_TOTAL) == rsp.last_result))
      else $error("last_result does not match the total transaction");
`endif

endmodule
